// ----- sv/lfrf_pkg.sv -----
// Package for the link frame receive filter: shared types and constants.
package lfrf_pkg;

  // Frame layout
  localparam int unsigned HEADER_BYTES = 13;
  localparam int unsigned MIN_FRAME    = 14;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_NET           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_AREA          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ADDRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_NET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_AREA    = 3'd5;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_RX,    // taking frame beats
    ST_LD,    // payload RAM data valid, load output register
    ST_WT     // result held until the sink takes it
  } lfrf_state_t;

endpackage

// ----- sv/lfrf_intf.sv -----
// Channel interfaces of the link frame receive filter: input, result and config.
interface lfrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface lfrf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] source_address;
  logic [7:0]  transaction;
  logic [7:0]  message_kind;
  logic [5:0]  payload_length;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        last;
  modport source (output valid, output source_address, output transaction,
                  output message_kind, output payload_length, output payload_byte,
                  output byte_valid, output last, input ready);
  modport sink   (input valid, input source_address, input transaction,
                  input message_kind, input payload_length, input payload_byte,
                  input byte_valid, input last, output ready);
endinterface

interface lfrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- sv/lfrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lfrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/link_frame_receive_filter.sv -----
// Throughput: one frame beat per cycle while receiving; no beats taken while results drain.
// The first result follows the checksum beat through ST_LD (RAM read) and the output load.
// Each further result follows acceptance of the previous one the same way (RAM read, load).
// Dropped frames and filtered frames produce no results and never leave the receive state.
// Reset (rst_n low, synchronous) returns to receive state, idle, and config to defaults;
// the payload RAM is not cleared, every entry is written before it is read.
module link_frame_receive_filter #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic clk,
  input  logic rst_n,
  lfrf_in_if.sink    in_ch,
  lfrf_out_if.source out_ch,
  lfrf_cfg_if.sink   cfg_ch
);
  import lfrf_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_FRAME - MIN_FRAME;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam logic [7:0]  MaxLen      = 8'(MAX_FRAME);
  localparam logic [7:0]  MinLen      = 8'(MIN_FRAME);
  localparam logic [7:0]  HdrLen      = 8'(HEADER_BYTES);

  // configuration registers
  logic [15:0] own_address_r, own_net_r, bc_address_r, bc_net_r;
  logic [31:0] own_area_r, bc_area_r;

  // frame tracking
  lfrf_state_t state_r, state_nxt;
  logic [7:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        in_frame_r, in_frame_nxt;

  // header fields
  logic [31:0] area_r;
  logic [15:0] net_r, dest_r, source_r;
  logic [7:0]  trans_r, kind_r;

  // emit counter and output register
  logic [AW-1:0] k_r, k_nxt;
  logic          out_valid_r;
  logic [15:0]   o_source_r;
  logic [7:0]    o_trans_r, o_kind_r, o_byte_r;
  logic [5:0]    o_len_r;
  logic          o_bvalid_r, o_last_r;

  logic          in_ready, in_fire, out_fire, body_beat, frame_end, addr_ok, frame_ok;
  logic [7:0]    n_pay, wofs;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  logic          res_last;

  // config write port, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
      own_net_r     <= '0;
      own_area_r    <= '0;
      bc_address_r  <= 16'hFFFF;
      bc_net_r      <= 16'hFFFF;
      bc_area_r     <= 32'hFFFF_FFFF;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_OWN_ADDRESS:       own_address_r <= cfg_ch.wr_data[15:0];
        REG_OWN_NET:           own_net_r     <= cfg_ch.wr_data[15:0];
        REG_OWN_AREA:          own_area_r    <= cfg_ch.wr_data;
        REG_BROADCAST_ADDRESS: bc_address_r  <= cfg_ch.wr_data[15:0];
        REG_BROADCAST_NET:     bc_net_r      <= cfg_ch.wr_data[15:0];
        REG_BROADCAST_AREA:    bc_area_r     <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = out_valid_r && out_ch.ready;

  // frame decode
  assign body_beat = in_fire && !in_ch.frame_start && in_frame_r;
  assign frame_end = body_beat && (byte_index_r == frame_length_r - 8'd1);
  assign addr_ok   = (area_r == own_area_r || area_r == bc_area_r) &&
                     (net_r == own_net_r || net_r == bc_net_r) &&
                     (dest_r == own_address_r || dest_r == bc_address_r);
  assign frame_ok  = frame_end && (in_ch.rx_byte == sum_r) && addr_ok;
  assign n_pay     = frame_length_r - MinLen;
  assign res_last  = (n_pay == 8'd0) || ({{(8-AW){1'b0}}, k_r} == n_pay - 8'd1);

  // frame counters
  always_comb begin
    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    sum_nxt          = sum_r;
    in_frame_nxt     = in_frame_r;
    if (in_fire && in_ch.frame_start) begin
      byte_index_nxt   = 8'd1;
      frame_length_nxt = in_ch.rx_byte;
      sum_nxt          = in_ch.rx_byte;
      in_frame_nxt     = (in_ch.rx_byte >= MinLen) && (in_ch.rx_byte <= MaxLen);
    end else if (frame_end) begin
      byte_index_nxt = 8'd0;
      in_frame_nxt   = 1'b0;
    end else if (body_beat) begin
      byte_index_nxt = byte_index_r + 8'd1;
      sum_nxt        = sum_r + in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= '0;
      frame_length_r <= '0;
      sum_r          <= '0;
      in_frame_r     <= 1'b0;
    end else begin
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
      sum_r          <= sum_nxt;
      in_frame_r     <= in_frame_nxt;
    end
  end

  // header shift-in; all header bytes precede the checksum so no clear is needed
  always_ff @(posedge clk) begin
    if (body_beat && !frame_end) begin
      case (byte_index_r) inside
        [8'd1:8'd4]:   area_r   <= {area_r[23:0], in_ch.rx_byte};
        [8'd5:8'd6]:   net_r    <= {net_r[7:0], in_ch.rx_byte};
        [8'd7:8'd8]:   dest_r   <= {dest_r[7:0], in_ch.rx_byte};
        [8'd9:8'd10]:  source_r <= {source_r[7:0], in_ch.rx_byte};
        8'd11:         trans_r  <= in_ch.rx_byte;
        8'd12:         kind_r   <= in_ch.rx_byte;
        default: ;
      endcase
    end
  end

  // payload write; only while receiving, so it never meets an emit read
  assign wofs      = byte_index_r - HdrLen;
  assign ram_we    = body_beat && !frame_end && (byte_index_r >= HdrLen);
  assign ram_waddr = wofs[AW-1:0];
  assign ram_raddr = k_nxt;

  lfrf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RX: if (frame_ok) state_nxt = ST_LD;
      ST_LD: state_nxt = ST_WT;
      ST_WT: begin
        if (out_fire) state_nxt = o_last_r ? ST_RX : ST_LD;
      end
      default: state_nxt = ST_RX;
    endcase
  end

  // sequencer outputs: input ready and RAM read address
  always_comb begin
    in_ready = 1'b0;
    k_nxt    = k_r;
    unique case (state_r)
      ST_RX: begin
        in_ready = 1'b1;
        k_nxt    = '0;
      end
      ST_LD: ;
      ST_WT: begin
        if (out_fire) k_nxt = o_last_r ? '0 : AW'(k_r + 1'b1);
      end
      default: k_nxt = '0;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RX;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (state_r == ST_LD) out_valid_r <= 1'b1;
      else if (out_fire)    out_valid_r <= 1'b0;
    end
  end

  // output register load
  always_ff @(posedge clk) begin
    if (state_r == ST_LD) begin
      o_source_r <= source_r;
      o_trans_r  <= trans_r;
      o_kind_r   <= kind_r;
      o_len_r    <= n_pay[5:0];
      o_byte_r   <= (n_pay == 8'd0) ? 8'd0 : ram_rdata;
      o_bvalid_r <= (n_pay != 8'd0);
      o_last_r   <= res_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.source_address = o_source_r;
  assign out_ch.transaction    = o_trans_r;
  assign out_ch.message_kind   = o_kind_r;
  assign out_ch.payload_length = o_len_r;
  assign out_ch.payload_byte   = o_byte_r;
  assign out_ch.byte_valid     = o_bvalid_r;
  assign out_ch.last           = o_last_r;

`ifndef SYNTHESIS
  a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_WT)
    else $error("result valid outside wait state");

  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LD |=> out_valid_r)
    else $error("load state did not present a result");

  a_frame_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (frame_length_r >= MinLen && frame_length_r <= MaxLen))
    else $error("frame length out of range while in frame");

  a_index_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> byte_index_r < frame_length_r)
    else $error("byte index ran past frame length");

  a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RX) |-> !in_ready)
    else $error("input taken while results drain");
`endif

endmodule
